FILE: hw/rtl/rabq_pkg.sv
// Shared types and constants of the row absmax int8 quantizer.
`timescale 1ns / 1ps

package rabq_pkg;

	// Input and result codes
	localparam logic FUNC_MEASURE = 1'b0;
	localparam logic FUNC_QUANT   = 1'b1;
	localparam logic KIND_SCALE   = 1'b0;
	localparam logic KIND_ELEM    = 1'b1;

	// fp32 / bf16 bit patterns and the int8 limit
	localparam logic [31:0] FP32_CANON_NAN = 32'h7FC0_0000;
	localparam logic [31:0] FP32_INF       = 32'h7F80_0000;
	localparam logic [31:0] FP32_ONE       = 32'h3F80_0000;
	localparam logic [31:0] FP32_QMAX      = 32'h42FE_0000;
	localparam logic [14:0] BF16_ABS_INF   = 15'h7F80;
	localparam logic [7:0]  INT8_QMAX      = 8'sd127;

	// Controller to datapath commands
	typedef struct packed {
		logic max_upd;
		logic elem_cap;
		logic scale_go;
		logic scale_cap;
		logic recip_go;
		logic recip_cap;
		logic q_mul;
		logic q_r32;
		logic q_r16;
		logic emit_scale;
		logic emit_q;
	} rabq_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic max_nan;
		logic scale_zero;
		logic div_done;
		logic out_busy;
	} rabq_status_t;

endpackage

FILE: hw/rtl/rabq_in_if.sv
// Input channel: one row element beat per handshake.
`timescale 1ns / 1ps

interface rabq_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [15:0] element;
	logic        last;

	modport source (output valid, output func, output element, output last, input ready);
	modport sink (input valid, input func, input element, input last, output ready);
endinterface

FILE: hw/rtl/rabq_out_if.sv
// Result channel: a row scale or a quantized element per beat.
`timescale 1ns / 1ps

interface rabq_out_if;
	logic              valid;
	logic              ready;
	logic              kind;
	logic [31:0]       scale_bits;
	logic signed [7:0] value;

	modport source (output valid, output kind, output scale_bits, output value, input ready);
	modport sink (input valid, input kind, input scale_bits, input value, output ready);
endinterface

FILE: hw/rtl/rabq_fdiv.sv
// Iterative fp32 divider for positive operands, round to nearest even, subnormals kept.
`timescale 1ns / 1ps

module rabq_fdiv import rabq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        done,
	output logic [31:0] res
);

	typedef enum logic [2:0] {D_IDLE, D_NORM, D_DIV, D_NQ, D_DEN, D_RND} dstate_t;

	dstate_t            state_q;
	logic [23:0]        sa_q, sb_q;
	logic signed [9:0]  ea_q, eb_q;
	logic signed [10:0] exp_q;
	logic [24:0]        rem_q;
	logic [26:0]        quo_q;
	logic [4:0]         cnt_q;
	logic [26:0]        w_q;
	logic               stk_q;
	logic               done_q;
	logic [31:0]        res_q;

	// One restoring step
	logic [25:0] diff;
	logic        ge;
	logic [24:0] rem_nx;
	assign diff   = {1'b0, rem_q} - {2'b00, sb_q};
	assign ge     = ~diff[25];
	assign rem_nx = ge ? {diff[23:0], 1'b0} : {rem_q[23:0], 1'b0};

	// Final rounding; a carry out of the mantissa bumps the exponent field
	logic [23:0] mant;
	logic        rinc;
	logic [7:0]  field;
	logic [31:0] rnd;
	assign mant  = w_q[26:3];
	assign rinc  = w_q[2] & ((|w_q[1:0]) | stk_q | mant[0]);
	assign field = mant[23] ? exp_q[7:0] : 8'd0;
	assign rnd   = {1'b0, field, mant[22:0]} + {31'd0, rinc};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			sa_q    <= '0;
			sb_q    <= '0;
			ea_q    <= '0;
			eb_q    <= '0;
			exp_q   <= '0;
			rem_q   <= '0;
			quo_q   <= '0;
			cnt_q   <= '0;
			w_q     <= '0;
			stk_q   <= 1'b0;
			done_q  <= 1'b0;
			res_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (start) begin
						if (a[30:0] == 31'd0 || b[30:23] == 8'hFF) begin
							res_q  <= '0;
							done_q <= 1'b1;
						end else if (a[30:23] == 8'hFF) begin
							res_q  <= FP32_INF;
							done_q <= 1'b1;
						end else begin
							sa_q    <= {|a[30:23], a[22:0]};
							sb_q    <= {|b[30:23], b[22:0]};
							ea_q    <= (a[30:23] == 8'd0) ? 10'sd1 : $signed({2'b00, a[30:23]});
							eb_q    <= (b[30:23] == 8'd0) ? 10'sd1 : $signed({2'b00, b[30:23]});
							state_q <= D_NORM;
						end
					end
				end
				// Left-justify subnormal significands, one bit a cycle
				D_NORM: begin
					if (sa_q[23] && sb_q[23]) begin
						exp_q   <= 11'(ea_q) - 11'(eb_q) + 11'sd127;
						rem_q   <= {1'b0, sa_q};
						quo_q   <= '0;
						cnt_q   <= '0;
						state_q <= D_DIV;
					end else begin
						if (!sa_q[23]) begin
							sa_q <= {sa_q[22:0], 1'b0};
							ea_q <= ea_q - 10'sd1;
						end
						if (!sb_q[23]) begin
							sb_q <= {sb_q[22:0], 1'b0};
							eb_q <= eb_q - 10'sd1;
						end
					end
				end
				// One quotient bit a cycle, 27 bits
				D_DIV: begin
					quo_q <= {quo_q[25:0], ge};
					rem_q <= rem_nx;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd26) begin
						state_q <= D_NQ;
					end
				end
				D_NQ: begin
					if (quo_q[26]) begin
						w_q <= quo_q;
					end else begin
						w_q   <= {quo_q[25:0], 1'b0};
						exp_q <= exp_q - 11'sd1;
					end
					stk_q   <= |rem_q;
					state_q <= D_DEN;
				end
				// Subnormal result: shift right until the exponent reaches one or the significand is zero
				D_DEN: begin
					if (exp_q < 11'sd1 && w_q != 27'd0) begin
						w_q   <= {1'b0, w_q[26:1]};
						stk_q <= stk_q | w_q[0];
						exp_q <= exp_q + 11'sd1;
					end else begin
						state_q <= D_RND;
					end
				end
				D_RND: begin
					res_q   <= (exp_q >= 11'sd255) ? FP32_INF : rnd;
					done_q  <= 1'b1;
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

FILE: hw/rtl/rabq_datapath.sv
// Datapath: running max, scale and reciprocal registers, quantize stages, result register.
`timescale 1ns / 1ps

module rabq_datapath import rabq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  rabq_cmd_t         cmd,
	output rabq_status_t      status,
	input  logic [15:0]       in_element,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              out_kind,
	output logic [31:0]       out_scale_bits,
	output logic signed [7:0] out_value
);

	typedef enum logic [1:0] {QC_ZERO, QC_SAT, QC_FIN} qclass_t;

	logic [14:0] max_q;
	logic [31:0] scale_q;
	logic [31:0] recip_q;
	logic [15:0] elem_q;

	// Running absolute maximum
	logic [14:0] abs_in;
	logic [14:0] max_nx;
	assign abs_in = in_element[14:0];
	assign max_nx = (abs_in > max_q) ? abs_in : max_q;

	// Shared divider: max/127 first, then 1/scale
	logic        div_start;
	logic [31:0] div_a, div_b;
	logic        div_done;
	logic [31:0] div_res;
	logic        max_nan;
	logic        scale_zero;

	assign max_nan    = max_q > BF16_ABS_INF;
	assign scale_zero = scale_q[30:0] == 31'd0;
	assign div_start  = (cmd.scale_go & ~max_nan) | (cmd.recip_go & ~scale_zero);
	assign div_a      = cmd.recip_go ? FP32_ONE : {1'b0, max_q, 16'h0000};
	assign div_b      = cmd.recip_go ? scale_q : FP32_QMAX;

	rabq_fdiv u_fdiv (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.a     (div_a),
		.b     (div_b),
		.done  (div_done),
		.res   (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q   <= '0;
			scale_q <= '0;
			recip_q <= '0;
			elem_q  <= '0;
		end else begin
			if (cmd.max_upd) begin
				max_q <= max_nx;
			end
			if (cmd.scale_go) begin
				max_q <= '0;
				if (max_nan) begin
					scale_q <= FP32_CANON_NAN;
					recip_q <= FP32_CANON_NAN;
				end
			end
			if (cmd.scale_cap) begin
				scale_q <= div_res;
			end
			if (cmd.recip_go && scale_zero) begin
				recip_q <= '0;
			end
			if (cmd.recip_cap) begin
				recip_q <= div_res;
			end
			if (cmd.elem_cap) begin
				elem_q <= in_element;
			end
		end
	end

	// Stage 1: classify, normalize the bf16 significand, multiply
	logic [7:0]        e_a;
	logic [6:0]        m_a;
	logic              e_zero, e_inf, e_nan, r_zero, r_inf, r_nan;
	qclass_t           cls;
	logic [7:0]        sa0, sa_n;
	logic [2:0]        lz;
	logic signed [9:0] ea;
	logic [31:0]       prod;
	logic signed [10:0] xb;

	assign e_a    = elem_q[14:7];
	assign m_a    = elem_q[6:0];
	assign e_zero = elem_q[14:0] == 15'd0;
	assign e_inf  = e_a == 8'hFF && m_a == 7'd0;
	assign e_nan  = e_a == 8'hFF && m_a != 7'd0;
	assign r_zero = recip_q == 32'd0;
	assign r_inf  = recip_q == FP32_INF;
	assign r_nan  = recip_q == FP32_CANON_NAN;
	assign sa0    = {|e_a, m_a};

	always_comb begin
		priority if (r_nan || e_nan || (e_inf && r_zero) || (e_zero && r_inf)) begin
			cls = QC_ZERO;
		end else if (e_inf || r_inf) begin
			cls = QC_SAT;
		end else if (e_zero || r_zero) begin
			cls = QC_ZERO;
		end else begin
			cls = QC_FIN;
		end
	end

	always_comb begin
		priority casez (sa0)
			8'b1???????: lz = 3'd0;
			8'b01??????: lz = 3'd1;
			8'b001?????: lz = 3'd2;
			8'b0001????: lz = 3'd3;
			8'b00001???: lz = 3'd4;
			8'b000001??: lz = 3'd5;
			8'b0000001?: lz = 3'd6;
			default:     lz = 3'd7;
		endcase
	end

	assign sa_n = sa0 << lz;
	assign ea   = ((e_a == 8'd0) ? 10'sd1 : $signed({2'b00, e_a})) - $signed({7'd0, lz});
	assign prod = sa_n * {1'b1, recip_q[22:0]};
	assign xb   = 11'(ea) + $signed({3'b000, recip_q[30:23]}) - 11'sd254;

	logic [31:0]        n_s1;
	logic signed [10:0] xb_s1;
	logic               neg_s1;
	qclass_t            cls_s1;

	// Stage 2: round the product to fp32
	logic signed [10:0] x2;
	logic [23:0]        sig24;
	logic               g32, st32, inc32;
	logic [24:0]        s25;

	assign x2    = xb_s1 + $signed({10'd0, n_s1[31]});
	assign sig24 = n_s1[31] ? n_s1[31:8] : n_s1[30:7];
	assign g32   = n_s1[31] ? n_s1[7] : n_s1[6];
	assign st32  = n_s1[31] ? (|n_s1[6:0]) : (|n_s1[5:0]);
	assign inc32 = g32 & (st32 | sig24[0]);
	assign s25   = {1'b0, sig24} + {24'd0, inc32};

	logic [23:0]        r24_s2;
	logic signed [10:0] x_s2;
	logic               neg_s2;
	qclass_t            cls_s2;

	// Stage 3: round to fp16, then to an integer with ties to even
	logic [11:0]        h;
	logic               inc16;
	logic signed [10:0] shc;
	logic [3:0]         sh;
	logic [11:0]        qv, remv, half, mag;
	logic               up;
	logic [7:0]         mag8;
	logic signed [7:0]  qres;

	assign inc16 = r24_s2[12] & ((|r24_s2[11:0]) | r24_s2[13]);
	assign h     = {1'b0, r24_s2[23:13]} + {11'd0, inc16};
	assign shc   = 11'sd10 - x_s2;
	assign sh    = shc[3:0];
	assign qv    = h >> sh;
	assign remv  = h & ((12'd1 << sh) - 12'd1);
	assign half  = 12'd1 << (sh - 4'd1);
	assign up    = (remv > half) || (remv == half && qv[0]);
	assign mag   = qv + {11'd0, up};

	always_comb begin
		unique case (cls_s2)
			QC_SAT:  mag8 = INT8_QMAX;
			QC_FIN: begin
				priority if (x_s2 >= 11'sd8) begin
					mag8 = INT8_QMAX;
				end else if (x_s2 <= -11'sd3) begin
					mag8 = 8'd0;
				end else if (mag > 12'd127) begin
					mag8 = INT8_QMAX;
				end else begin
					mag8 = mag[7:0];
				end
			end
			default: mag8 = 8'd0;
		endcase
		qres = neg_s2 ? -$signed(mag8) : $signed(mag8);
	end

	logic signed [7:0] qval_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_s1    <= '0;
			xb_s1   <= '0;
			neg_s1  <= 1'b0;
			cls_s1  <= QC_ZERO;
			r24_s2  <= '0;
			x_s2    <= '0;
			neg_s2  <= 1'b0;
			cls_s2  <= QC_ZERO;
			qval_s3 <= '0;
		end else begin
			if (cmd.q_mul) begin
				n_s1   <= prod;
				xb_s1  <= xb;
				neg_s1 <= elem_q[15];
				cls_s1 <= cls;
			end
			if (cmd.q_r32) begin
				r24_s2 <= s25[24] ? 24'h80_0000 : s25[23:0];
				x_s2   <= x2 + $signed({10'd0, s25[24]});
				neg_s2 <= neg_s1;
				cls_s2 <= cls_s1;
			end
			if (cmd.q_r16) begin
				qval_s3 <= qres;
			end
		end
	end

	// Result register
	logic              out_valid_q;
	logic              out_kind_q;
	logic [31:0]       out_scale_q;
	logic signed [7:0] out_val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_kind_q  <= KIND_SCALE;
			out_scale_q <= '0;
			out_val_q   <= '0;
		end else begin
			if (cmd.emit_scale || cmd.emit_q) begin
				out_valid_q <= 1'b1;
				out_kind_q  <= cmd.emit_q ? KIND_ELEM : KIND_SCALE;
				out_scale_q <= scale_q;
				out_val_q   <= cmd.emit_q ? qval_s3 : 8'sd0;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign out_kind       = out_kind_q;
	assign out_scale_bits = out_scale_q;
	assign out_value      = out_val_q;

	assign status.max_nan    = max_nan;
	assign status.scale_zero = scale_zero;
	assign status.div_done   = div_done;
	assign status.out_busy   = out_valid_q & ~out_ready;

endmodule

FILE: hw/rtl/rabq_ctrl.sv
// Controller: sequences measure, scale/reciprocal division and quantize steps.
`timescale 1ns / 1ps

module rabq_ctrl import rabq_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic         in_func,
	input  logic         in_last,
	input  rabq_status_t status,
	output rabq_cmd_t    cmd
);

	typedef enum logic [3:0] {
		C_IDLE, C_SCALE, C_WAIT_S, C_RECIP, C_WAIT_R, C_EMIT_S,
		C_QMUL, C_QR32, C_QR16, C_EMIT_Q
	} cstate_t;

	cstate_t state_q, state_nx;

	// Command decode and next state
	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			C_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_func == FUNC_MEASURE) begin
						cmd.max_upd = 1'b1;
						if (in_last) begin
							state_nx = C_SCALE;
						end
					end else begin
						cmd.elem_cap = 1'b1;
						state_nx     = C_QMUL;
					end
				end
			end
			C_SCALE: begin
				cmd.scale_go = 1'b1;
				state_nx     = status.max_nan ? C_EMIT_S : C_WAIT_S;
			end
			C_WAIT_S: begin
				if (status.div_done) begin
					cmd.scale_cap = 1'b1;
					state_nx      = C_RECIP;
				end
			end
			C_RECIP: begin
				cmd.recip_go = 1'b1;
				state_nx     = status.scale_zero ? C_EMIT_S : C_WAIT_R;
			end
			C_WAIT_R: begin
				if (status.div_done) begin
					cmd.recip_cap = 1'b1;
					state_nx      = C_EMIT_S;
				end
			end
			C_EMIT_S: begin
				if (!status.out_busy) begin
					cmd.emit_scale = 1'b1;
					state_nx       = C_IDLE;
				end
			end
			C_QMUL: begin
				cmd.q_mul = 1'b1;
				state_nx  = C_QR32;
			end
			C_QR32: begin
				cmd.q_r32 = 1'b1;
				state_nx  = C_QR16;
			end
			C_QR16: begin
				cmd.q_r16 = 1'b1;
				state_nx  = C_EMIT_Q;
			end
			C_EMIT_Q: begin
				if (!status.out_busy) begin
					cmd.emit_q = 1'b1;
					state_nx   = C_IDLE;
				end
			end
			default: state_nx = C_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

FILE: hw/rtl/row_absmax_int8_quantizer_top.sv
// Top level of the per-row absmax symmetric int8 quantizer.
`timescale 1ns / 1ps

// Each row is streamed twice. Measure beats (func 0) fold |element| into a running
// maximum and are accepted back to back. The beat marked last starts the shared
// iterative fp32 divider, first for max/127 and then for 1/scale. The divider
// normalizes one bit a cycle, makes one quotient bit a cycle and denormalizes one bit a
// cycle. Subnormal values add normalizing and denormalizing steps. A NaN row skips the
// divider, a zero row skips 1/scale, and an infinite row needs no divider iterations.
// Quantize beats (func 1) go through a multiply stage and two rounding stages. Each beat
// is captured, then passes C_QMUL, C_QR32 and C_QR16 and waits in C_EMIT_Q while the
// result register is busy, one item at a time. The result register lets the next beat
// in while a result still waits to be taken. An all-zero row gives scale 0 and zeros.
module row_absmax_int8_quantizer_top import rabq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	rabq_in_if.sink   items,
	rabq_out_if.source results
);

	rabq_cmd_t    cmd;
	rabq_status_t status;

	rabq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(items.valid),
		.in_ready(items.ready),
		.in_func (items.func),
		.in_last (items.last),
		.status  (status),
		.cmd     (cmd)
	);

	rabq_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.in_element    (items.element),
		.out_valid     (results.valid),
		.out_ready     (results.ready),
		.out_kind      (results.kind),
		.out_scale_bits(results.scale_bits),
		.out_value     (results.value)
	);

`ifndef SYNTHESIS
	// A quantize beat occupies the block for its rounding stages
	a_quant_busy: assert property (@(posedge clk) disable iff (!arst_n)
		items.valid && items.ready && items.func == FUNC_QUANT |=> !items.ready)
		else $error("input ready right after a quantize beat");

	// A new result only appears out of a busy (emit) state
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(results.valid) |-> !$past(items.ready))
		else $error("result appeared without work in flight");

	// Quantized values never reach -128
	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.kind == KIND_ELEM |-> results.value != -8'sd128)
		else $error("quantized value out of range");
`endif

endmodule
